// File: rtl/wrf_pkg.sv
// ----------------------------------------------------------------------------
// wrf_pkg
// types and constants shared by the windowed register file modules
// ----------------------------------------------------------------------------
`default_nettype none

package wrf_pkg;

  localparam int DATA_W       = 32;
  localparam int REG_W        = 5;
  localparam int WIN_W        = 5;
  localparam int GLOBAL_COUNT = 8;
  localparam int GLOBAL_AW    = 3;
  localparam int WINDOW_SPAN  = 16;

  // operation codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_READ       = 2'd0,
    KIND_WRITE      = 2'd1,
    KIND_SET_WINDOW = 2'd2,
    KIND_NONE       = 2'd3
  } wrf_kind_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [REG_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_value;
    logic [WIN_W-1:0]  new_window;
  } wrf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [WIN_W-1:0]  current_window;
    logic              range_error;
  } wrf_out_t;

  // access command toward the window memory
  typedef struct packed {
    logic rd;
    logic wr;
  } wrf_mem_cmd_t;

endpackage

`default_nettype wire

// File: rtl/wrf_globals.sv
// ----------------------------------------------------------------------------
// wrf_globals
// eight global registers, register zero hardwired to zero
// ----------------------------------------------------------------------------
`default_nettype none

module wrf_globals
  import wrf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [GLOBAL_AW-1:0] addr,
  input  wire logic [DATA_W-1:0]    wdata,
  output logic      [DATA_W-1:0]    rdata
);

  logic [DATA_W-1:0] regs [GLOBAL_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GLOBAL_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else if (we && (addr != '0)) begin
      regs[addr] <= wdata;
    end
  end

  assign rdata = regs[addr];

endmodule

`default_nettype wire

// File: rtl/wrf_window_mem.sv
// ----------------------------------------------------------------------------
// wrf_window_mem
// windowed register storage, one port, registered read, zero sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module wrf_window_mem
  import wrf_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wrf_mem_cmd_t         cmd,
  input  wire logic [AW-1:0]        addr,
  input  wire logic [DATA_W-1:0]    wdata,
  output logic      [DATA_W-1:0]    rdata,
  output logic                      ready
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic              clearing;
  logic [AW-1:0]     clr_addr;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

// File: rtl/windowed_register_file_unit.sv
// ----------------------------------------------------------------------------
// windowed_register_file_unit
// integer register file with overlapping register windows
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req) carries one access per beat:
//   read a visible register, write one, or set the current window pointer.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one beat per request
//   with the read data, the window pointer after the access and a flag for
//   a rejected window pointer.
//   a request goes through the read stage and the output register to rsp.
//   throughput: one request per cycle while req_stall is low; the
//   single-port window memory does one read or one write per cycle and
//   the next access sees what the previous one wrote.
//   reset: globals clear at once and the window pointer goes to the last
//   window; the window memory is then zeroed one entry per cycle, and
//   req_stall stays high during that sweep.
//   a stalled rsp holds its beat; one more request can sit in the read
//   stage, after which req_stall rises until rsp drains.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_register_file_unit
  import wrf_pkg::*;
#(
  parameter int NUM_WINDOWS = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  input  wire wrf_in_t req,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output wrf_out_t     rsp
);

  localparam int TOTAL = WINDOW_SPAN * NUM_WINDOWS;
  localparam int AW    = $clog2(TOTAL);
  localparam int PW    = $clog2(NUM_WINDOWS);
  localparam logic [AW:0]      TOTAL_V  = (AW+1)'(TOTAL);
  localparam logic [WIN_W:0]   NWIN_V   = (WIN_W+1)'(NUM_WINDOWS);
  localparam logic [PW-1:0]    CWP_INIT = PW'(NUM_WINDOWS - 1);
  localparam logic [REG_W-1:0] FIRST_WIN_REG = REG_W'(GLOBAL_COUNT);

  // current window pointer
  logic [PW-1:0] cwp;
  logic [PW-1:0] cwp_next;

  // decode of the request
  logic          accept;
  logic          is_global;
  logic          is_read;
  logic          is_write;
  logic          is_set;
  logic          win_ok;
  logic [AW:0]   raw_slot;
  logic [AW:0]   slot;

  // read stage
  logic              s1_valid;
  logic              s1_adv;
  logic              s1_from_mem;
  logic [DATA_W-1:0] s1_gval;
  logic [WIN_W-1:0]  s1_cwp;
  logic              s1_err;

  // storage side
  wrf_mem_cmd_t      mem_cmd;
  logic [DATA_W-1:0] mem_rdata;
  logic              mem_ready;
  logic [DATA_W-1:0] g_rdata;
  logic              g_we;

  // registers 0..7 are globals
  assign is_global = (req.reg_index[4:3] == 2'b00);

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_set   = 1'b0;
    unique case (wrf_kind_t'(req.kind))
      KIND_READ:       is_read  = 1'b1;
      KIND_WRITE:      is_write = 1'b1;
      KIND_SET_WINDOW: is_set   = 1'b1;
      KIND_NONE:       ;
      default:         ;
    endcase
  end

  // window slot: cwp*16 + reg - 8 stays below twice the store size,
  // so one compare and subtract does the wrap
  assign raw_slot = (AW+1)'({cwp, 4'b0000})
                  + (AW+1)'(req.reg_index - FIRST_WIN_REG);
  assign slot     = (raw_slot >= TOTAL_V) ? (raw_slot - TOTAL_V) : raw_slot;

  // out-of-range pointer requests are rejected
  assign win_ok = ((WIN_W+1)'(req.new_window) < NWIN_V);

  always_comb begin
    cwp_next = cwp;
    if (is_set && win_ok) begin
      cwp_next = req.new_window[PW-1:0];
    end
  end

  // one beat may wait in the read stage while rsp is blocked
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = !mem_ready || (s1_valid && !s1_adv);
  assign accept    = req_valid && !req_stall;

  assign mem_cmd.rd = accept && is_read && !is_global;
  assign mem_cmd.wr = accept && is_write && !is_global;
  assign g_we       = accept && is_write && is_global;

  wrf_globals u_globals (
    .clk   (clk),
    .rst   (rst),
    .we    (g_we),
    .addr  (req.reg_index[GLOBAL_AW-1:0]),
    .wdata (req.write_value),
    .rdata (g_rdata)
  );

  wrf_window_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_window_mem (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mem_cmd),
    .addr  (slot[AW-1:0]),
    .wdata (req.write_value),
    .rdata (mem_rdata),
    .ready (mem_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cwp <= CWP_INIT;
    end else if (accept) begin
      cwp <= cwp_next;
    end
  end

  // read stage: globals are captured here, window data arrives from memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from_mem <= is_read && !is_global;
      s1_gval     <= (is_read && is_global) ? g_rdata : '0;
      s1_cwp      <= WIN_W'(cwp_next);
      s1_err      <= is_set && !win_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.read_value     <= s1_from_mem ? mem_rdata : s1_gval;
      rsp.current_window <= s1_cwp;
      rsp.range_error    <= s1_err;
    end
  end

`ifndef SYNTHESIS
  // a rejected pointer update never carries read data
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.range_error |-> rsp.read_value == '0)
    else $error("range error beat with nonzero read data");

  // the reported window pointer is always a legal window
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (WIN_W+1)'(rsp.current_window) < NWIN_V)
    else $error("window pointer out of range");

  // a beat in the read stage is kept while the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && rsp_stall |=> s1_valid && rsp_valid)
    else $error("beat lost behind stalled response");

  // no access reaches the window memory during the zero sweep
  assert property (@(posedge clk) disable iff (rst)
    !mem_ready |-> !mem_cmd.rd && !mem_cmd.wr && !accept)
    else $error("access during memory clear");
`endif

endmodule

`default_nettype wire

// File: sim/wrf_checker.sv
// ----------------------------------------------------------------------------
// wrf_checker
// watches both channels of the windowed register file, predicts each
// response beat from its own copy of the register state and compares
// ----------------------------------------------------------------------------
`default_nettype none

module wrf_checker
  import wrf_pkg::*;
#(
  parameter int NUM_WINDOWS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_stall,
  input  wire wrf_in_t  req,
  input  wire logic     rsp_valid,
  input  wire logic     rsp_stall,
  input  wire wrf_out_t rsp,
  output int            pending,
  output int            fail_count
);

  localparam int WINDOW_TOTAL = WINDOW_SPAN * NUM_WINDOWS;
  localparam int WIN_AW       = $clog2(WINDOW_TOTAL);

  logic [DATA_W-1:0] glob_regs [GLOBAL_COUNT];
  logic [DATA_W-1:0] win_regs  [WINDOW_TOTAL];
  logic [WIN_W-1:0]  cwp_model;

  wrf_out_t expected_rsp_q [$];
  int       mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // apply one access to the model and return the beat it should produce
  function automatic wrf_out_t apply_access(input wrf_in_t acc);
    wrf_out_t          res;
    logic [WIN_AW-1:0] slot;
    res  = '0;
    slot = WIN_AW'((int'(cwp_model) * WINDOW_SPAN + int'(acc.reg_index)
                    + WINDOW_TOTAL - 8) % WINDOW_TOTAL);
    case (wrf_kind_t'(acc.kind))
      KIND_READ: begin
        if (acc.reg_index < GLOBAL_COUNT)
          res.read_value = glob_regs[acc.reg_index[GLOBAL_AW-1:0]];
        else res.read_value = win_regs[slot];
      end
      KIND_WRITE: begin
        if (acc.reg_index < GLOBAL_COUNT) begin
          if (acc.reg_index != 0)
            glob_regs[acc.reg_index[GLOBAL_AW-1:0]] = acc.write_value;
        end else begin
          win_regs[slot] = acc.write_value;
        end
      end
      KIND_SET_WINDOW: begin
        if (acc.new_window < NUM_WINDOWS) cwp_model = acc.new_window;
        else res.range_error = 1'b1;
      end
      default: ;
    endcase
    res.current_window = cwp_model;
    return res;
  endfunction

  always @(posedge clk) begin
    wrf_out_t want;
    if (rst) begin
      foreach (glob_regs[i]) glob_regs[i] = '0;
      foreach (win_regs[i]) win_regs[i] = '0;
      cwp_model = WIN_W'(NUM_WINDOWS - 1);
      expected_rsp_q.delete();
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected beat, read_value", rsp.read_value, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", rsp.read_value, want.read_value);
          if (rsp.current_window !== want.current_window)
            report_mismatch("current_window", DATA_W'(rsp.current_window),
                            DATA_W'(want.current_window));
          if (rsp.range_error !== want.range_error)
            report_mismatch("range_error", DATA_W'(rsp.range_error),
                            DATA_W'(want.range_error));
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(apply_access(req));
      pending <= expected_rsp_q.size();
    end
  end

endmodule

`default_nettype wire

// File: sim/windowed_register_file_unit_tb.sv
// ----------------------------------------------------------------------------
// windowed_register_file_unit_tb
// drives register reads, writes and window changes into the register file
// with random gaps and back-pressure; a checker beside the block predicts
// and compares every response beat
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_register_file_unit_tb;
  import wrf_pkg::*;

  localparam int NUM_WIN      = 8;
  localparam int RANDOM_BEATS = 1000;
  localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on either side

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  wrf_in_t  req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  wrf_out_t rsp;
  int       pending;
  int       fail_count;

  windowed_register_file_unit #(
    .NUM_WINDOWS(NUM_WIN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  wrf_checker #(
    .NUM_WINDOWS(NUM_WIN)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // build one request beat
  function automatic wrf_in_t access(input wrf_kind_t k, input int r,
                                     input logic [DATA_W-1:0] v, input int w);
    wrf_in_t a;
    a.kind        = k;
    a.reg_index   = REG_W'(r);
    a.write_value = v;
    a.new_window  = WIN_W'(w);
    return a;
  endfunction

  // random access: mostly reads and writes, some window changes, a few
  // out-of-range pointers and unused kinds
  function automatic wrf_in_t random_access();
    wrf_in_t a;
    int      pick;
    a.reg_index = REG_W'($urandom_range(31));
    pick = $urandom_range(99);
    if (pick < 10) a.write_value = '0;
    else if (pick < 20) a.write_value = '1;
    else a.write_value = $urandom;
    if ($urandom_range(99) < 75) a.new_window = WIN_W'($urandom_range(NUM_WIN - 1));
    else a.new_window = WIN_W'($urandom_range(31, NUM_WIN));
    pick = $urandom_range(99);
    if (pick < 40) a.kind = KIND_READ;
    else if (pick < 75) a.kind = KIND_WRITE;
    else if (pick < 95) a.kind = KIND_SET_WINDOW;
    else a.kind = KIND_NONE;
    return a;
  endfunction

  // offer one beat, with random idle cycles ahead of it unless eager;
  // valid stays high after acceptance so back-to-back beats keep it up
  task automatic send_beat(input wrf_in_t item, input bit eager);
    if (!eager) begin
      while ($urandom_range(99) < 34) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // drop valid and wait until every predicted response has arrived
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stalls, a quiet stretch, and one long hold-off so the
  // block fills up and has to stall its request side
  initial begin : receiver
    int rsp_seen;
    int hold_left;
    bit hold_done;
    rsp_seen  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) rsp_seen++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_seen >= 600) begin
        hold_done = 1'b1;
        hold_left = 80;
        rsp_stall <= 1'b1;
      end else if (rsp_seen >= 300 && rsp_seen < 450) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 34);
      end
    end
  end

  // watchdog: ends the run if no beat moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL windowed_register_file_unit");
    $finish;
  end

  initial begin : stimulus
    wrf_in_t directed_q [$];
    // reset; the block then sweeps its window memory with req_stall high
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register zero ignores writes
    directed_q.push_back(access(KIND_READ, 0, '0, 0));
    directed_q.push_back(access(KIND_WRITE, 0, '1, 0));
    directed_q.push_back(access(KIND_READ, 0, '0, 0));
    // top global all ones, then global 1 with the value one
    directed_q.push_back(access(KIND_WRITE, 7, '1, 31));
    directed_q.push_back(access(KIND_READ, 7, '0, 0));
    directed_q.push_back(access(KIND_WRITE, 1, 32'h0000_0001, 0));
    directed_q.push_back(access(KIND_READ, 1, '0, 0));
    // last window after reset: first out, and last in wrapping to window 0
    directed_q.push_back(access(KIND_WRITE, 8, 32'ha5a5_a5a5, 0));
    directed_q.push_back(access(KIND_WRITE, 31, '1, 0));
    directed_q.push_back(access(KIND_SET_WINDOW, 0, '0, 0));
    directed_q.push_back(access(KIND_READ, 15, '0, 0));
    // ins of window 0 are the outs of window 1
    directed_q.push_back(access(KIND_WRITE, 24, 32'h1234_5678, 0));
    directed_q.push_back(access(KIND_SET_WINDOW, 0, '0, 1));
    directed_q.push_back(access(KIND_READ, 8, '0, 0));
    directed_q.push_back(access(KIND_READ, 16, '0, 0));
    // pointer out of range, lowest and highest
    directed_q.push_back(access(KIND_SET_WINDOW, 0, '0, NUM_WIN));
    directed_q.push_back(access(KIND_SET_WINDOW, 31, '1, 31));
    // unused kind with every field set
    directed_q.push_back(access(KIND_NONE, 31, '1, 31));
    // back to the last window and read what was left there
    directed_q.push_back(access(KIND_SET_WINDOW, 0, '0, NUM_WIN - 1));
    directed_q.push_back(access(KIND_READ, 8, '0, 0));
    directed_q.push_back(access(KIND_READ, 31, '0, 0));
    directed_q.push_back(access(KIND_WRITE, 31, '0, 0));
    directed_q.push_back(access(KIND_READ, 31, '0, 0));
    foreach (directed_q[i]) send_beat(directed_q[i], 1'b0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // sender pause until the block has fully drained
      if (n == 800) drain();
      // a stretch with no sender idling at all
      send_beat(random_access(), (n >= 300 && n < 450));
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS windowed_register_file_unit");
    end else begin
      $display("FAIL windowed_register_file_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
